// File: hw/rtl/mwcrm_pkg.sv
`timescale 1ns / 1ps

package mwcrm_pkg;

	localparam int WORD_W  = 32;
	localparam int HALF_W  = 16;
	localparam int VALUE_W = 31;
	localparam int CNT_W   = 5;

	localparam logic [HALF_W-1:0]  MULT_SECOND = 16'd36969;
	localparam logic [HALF_W-1:0]  MULT_FIRST  = 16'd18000;
	localparam logic [VALUE_W-1:0] LIMIT_RESET = 31'd4096;
	localparam logic [CNT_W-1:0]   LAST_STEP   = 5'd31;

	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [WORD_W-1:0] mwc_advance(input logic [WORD_W-1:0] w,
		input logic [HALF_W-1:0] mult);
		logic [WORD_W-1:0] prod;
		prod = {{HALF_W{1'b0}}, mult} * {{HALF_W{1'b0}}, w[HALF_W-1:0]};
		return prod + {{HALF_W{1'b0}}, w[WORD_W-1:HALF_W]};
	endfunction

endpackage

// File: hw/rtl/mwc_random_modulo.sv
`timescale 1ns / 1ps

// Dual multiply-with-carry random source whose draws are reduced modulo range_limit.
// A load transfer (action 1) sets both generator words and gives no result.
// A draw transfer (action 0) advances both words at acceptance, forms the 32-bit sum in
// the next cycle, then reduces it with a restoring divider that retires one quotient bit
// per cycle, one for each bit of the sum; no new transfer is taken until the result
// has moved into the output register, where it waits while the next item enters.
// A range_limit of zero yields zero; write range_limit only while no draw is in flight.
module mwc_random_modulo import mwcrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VALUE_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [WORD_W-1:0]  seed_first,
	input  logic [WORD_W-1:0]  seed_second,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] value
);

	state_t state_q, state_d;

	logic [VALUE_W-1:0] limit_q;
	logic [WORD_W-1:0]  word_first_q;
	logic [WORD_W-1:0]  word_second_q;
	logic [WORD_W-1:0]  dividend_q;
	logic [VALUE_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;

	logic              in_xfer;
	logic              out_free;
	logic [WORD_W-1:0] trial;
	logic              trial_ge;
	logic [WORD_W-1:0] trial_diff;
	logic [VALUE_W-1:0] rem_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	assign trial      = {rem_q, dividend_q[WORD_W-1]};
	assign trial_ge   = (trial >= {1'b0, limit_q});
	assign trial_diff = trial - {1'b0, limit_q};
	assign rem_next   = trial_ge ? trial_diff[VALUE_W-1:0] : trial[VALUE_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && action == ACT_DRAW) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			limit_q       <= LIMIT_RESET;
			word_first_q  <= '0;
			word_second_q <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (in_xfer) begin
				if (action == ACT_LOAD) begin
					word_first_q  <= seed_first;
					word_second_q <= seed_second;
				end else begin
					word_first_q  <= mwc_advance(word_first_q, MULT_FIRST);
					word_second_q <= mwc_advance(word_second_q, MULT_SECOND);
				end
			end
			if (state_q == ST_SUM) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			dividend_q <= {word_second_q[HALF_W-1:0], {HALF_W{1'b0}}} + word_first_q;
			rem_q      <= '0;
		end else if (state_q == ST_DIV) begin
			dividend_q <= {dividend_q[WORD_W-2:0], 1'b0};
			rem_q      <= rem_next;
		end
		if (state_q == ST_DONE && out_free) begin
			value_q <= (limit_q == '0) ? '0 : rem_q;
		end
	end

endmodule

// File: hw/rtl/mwc_random_modulo_chk.sv
`timescale 1ns / 1ps

module mwc_random_modulo_chk import mwcrm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [VALUE_W-1:0] cfg_wdata,
	input logic               in_valid,
	input logic               in_ready,
	input logic               action,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] value
);

	logic [VALUE_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result changed or dropped before its transfer");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_q != '0 |-> value < limit_q)
		else $error("result not below the range limit");

	a_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_q == '0 |-> value == '0)
		else $error("nonzero result with a zero range limit");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_LOAD |=> in_ready)
		else $error("load transfer held off the next input");

	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_DRAW |=> !in_ready)
		else $error("input taken while a draw is in progress");

endmodule

bind mwc_random_modulo mwc_random_modulo_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value)
);
